/* design/nearest_day_key_lookup_defines.svh */
// assertion macros shared by the nearest day key lookup rtl
`ifndef NEAREST_DAY_KEY_LOOKUP_DEFINES_SVH
`define NEAREST_DAY_KEY_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge outside reset
`define NDKL_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ndkl assertion failed");
// condition that must hold in the cycle after a trigger
`define NDKL_ASSERT_NEXT(name, trig, cond) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("ndkl assertion failed");
`else
`define NDKL_ASSERT(name, prop)
`define NDKL_ASSERT_NEXT(name, trig, cond)
`endif

`endif

/* design/ndkl_pkg.sv */
// shared constants and types of the nearest day key lookup
`default_nettype none

package ndkl_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 4096;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int TS_W    = 40;
    localparam int DAY_W   = 24;
    localparam int VAL_W   = 8;
    localparam int ENTRY_W = DAY_W + VAL_W;

    // day divider: 86400 = 128 * 675, the odd part by reciprocal multiply
    localparam int SECONDS_PER_DAY = 86400;
    localparam int DAY_SHIFT       = 7;
    localparam int DIV_ODD         = SECONDS_PER_DAY >> DAY_SHIFT;
    localparam int DIV_X_W         = TS_W - DAY_SHIFT;
    localparam int DIV_K           = 43;
    localparam int DIV_MAGIC_W     = 34;
    localparam int DIV_HALF_W      = DIV_MAGIC_W / 2;
    localparam int DIV_PROD_W      = DIV_X_W + DIV_HALF_W;
    localparam int DIV_SUM_W       = DIV_X_W + DIV_MAGIC_W;
    // ceil(2^43 / 675), exact floor for every 33 bit dividend
    localparam logic [DIV_MAGIC_W-1:0] DIV_MAGIC =
        DIV_MAGIC_W'(((64'd1 << DIV_K) + 64'(DIV_ODD) - 64'd1) / 64'(DIV_ODD));
    localparam logic [DIV_HALF_W-1:0]  DIV_MAGIC_LO = DIV_MAGIC[DIV_HALF_W-1:0];
    localparam logic [DIV_HALF_W-1:0]  DIV_MAGIC_HI = DIV_MAGIC[DIV_MAGIC_W-1:DIV_HALF_W];

    // answer for an empty table and reset value of the cache
    localparam logic [VAL_W-1:0] DEFAULT_VALUE = VAL_W'(50);

    // operation codes
    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    // control states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SEARCH,
        ST_NEAR_HI,
        ST_NEAR_LO,
        ST_EMIT
    } ndkl_state_t;

    // divider status toward the controller
    typedef struct packed {
        logic             done;
        logic [DAY_W-1:0] day;
    } ndkl_div_res_t;

endpackage

`default_nettype wire

/* design/ndkl_ram.sv */
// generic simple dual port ram with registered read data
`default_nettype none

module ndkl_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, read data registered
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* design/ndkl_day_div.sv */
// timestamp to day number divider by reciprocal multiplication, low and high product halves registered in turn
`default_nettype none

module ndkl_day_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [ndkl_pkg::TS_W-1:0]     timestamp,
    output ndkl_pkg::ndkl_div_res_t            res
);

    logic                              s1_reg, s1_next;
    logic                              s2_reg, s2_next;
    logic                              s3_reg, s3_next;
    logic                              done_reg, done_next;
    logic [ndkl_pkg::DIV_X_W-1:0]      x_reg, x_next;
    logic [ndkl_pkg::DIV_PROD_W-1:0]   plo_reg, plo_next;
    logic [ndkl_pkg::DIV_PROD_W-1:0]   phi_reg, phi_next;
    logic [ndkl_pkg::DAY_W-1:0]        quo_reg, quo_next;
    logic [ndkl_pkg::DIV_SUM_W-1:0]    sum;

    // x = timestamp / 128; day = (x * magic) >> 43, magic split in two halves
    always_comb
    begin
        s1_next   = start;
        s2_next   = s1_reg;
        s3_next   = s2_reg;
        done_next = s3_reg;
        x_next    = x_reg;
        plo_next  = plo_reg;
        phi_next  = phi_reg;
        quo_next  = quo_reg;
        sum       = {phi_reg, {ndkl_pkg::DIV_HALF_W{1'b0}}}
                    + ndkl_pkg::DIV_SUM_W'(plo_reg);
        if (start)
        begin
            x_next = timestamp[ndkl_pkg::TS_W-1:ndkl_pkg::DAY_SHIFT];
        end
        if (s1_reg)
        begin
            plo_next = ndkl_pkg::DIV_PROD_W'(x_reg)
                       * ndkl_pkg::DIV_PROD_W'(ndkl_pkg::DIV_MAGIC_LO);
        end
        if (s2_reg)
        begin
            phi_next = ndkl_pkg::DIV_PROD_W'(x_reg)
                       * ndkl_pkg::DIV_PROD_W'(ndkl_pkg::DIV_MAGIC_HI);
        end
        if (s3_reg)
        begin
            quo_next = sum[ndkl_pkg::DIV_SUM_W-1:ndkl_pkg::DIV_K];
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= 1'b0;
            s2_reg   <= 1'b0;
            s3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            s3_reg   <= s3_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        plo_reg <= plo_next;
        phi_reg <= phi_next;
        quo_reg <= quo_next;
    end

    assign res.done = done_reg;
    assign res.day  = quo_reg;

endmodule

`default_nettype wire

/* design/nearest_day_key_lookup.sv */
// top level: day keyed table with cached nearest key lookup
`default_nettype none
`include "nearest_day_key_lookup_defines.svh"

// Holds up to 4096 (day, value) entries in one synchronous ram, appended in
// load order; timestamps are floored to days by a reciprocal multiply after
// acceptance. One item is worked at a time. A load is accepted, goes through
// the divider, then is written to the ram before the next acceptance. A
// lookup goes straight to the output when the table is empty or the
// one-entry cache hits, otherwise it runs a binary search (up to 13 probes
// for a full table, one ram read each) and reads both neighbors on a miss.
// The result sits in an output register,
// so a new item is taken while it waits; a later lookup that finishes while
// that result is still stalled holds the input. Lookup ties go to the higher
// neighbor.
module nearest_day_key_lookup (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic                          operation,
    input  wire logic [ndkl_pkg::TS_W-1:0]     timestamp,
    input  wire logic [ndkl_pkg::VAL_W-1:0]    entry_value,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [ndkl_pkg::VAL_W-1:0]    looked_up_value
);

    ndkl_pkg::ndkl_state_t             state_reg, state_next;
    logic                              op_reg, op_next;
    logic [ndkl_pkg::VAL_W-1:0]        val_reg, val_next;
    logic [ndkl_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [ndkl_pkg::DAY_W-1:0]        cached_day_reg, cached_day_next;
    logic [ndkl_pkg::VAL_W-1:0]        cached_value_reg, cached_value_next;
    logic [ndkl_pkg::CNT_W-1:0]        lo_reg, lo_next;
    logic [ndkl_pkg::CNT_W-1:0]        hp_reg, hp_next;
    logic [ndkl_pkg::IDX_W-1:0]        mid_reg, mid_next;
    logic [ndkl_pkg::IDX_W-1:0]        lo_idx_reg, lo_idx_next;
    logic [ndkl_pkg::DAY_W-1:0]        dhi_reg, dhi_next;
    logic [ndkl_pkg::VAL_W-1:0]        hval_reg, hval_next;
    logic [ndkl_pkg::VAL_W-1:0]        res_reg, res_next;
    logic                              out_valid_reg, out_valid_next;
    logic [ndkl_pkg::VAL_W-1:0]        out_value_reg, out_value_next;

    logic                              div_start;
    ndkl_pkg::ndkl_div_res_t           div_res;
    logic [ndkl_pkg::DAY_W-1:0]        day;

    logic                              ram_we;
    logic [ndkl_pkg::IDX_W-1:0]        ram_raddr;
    logic [ndkl_pkg::ENTRY_W-1:0]      ram_wdata;
    logic [ndkl_pkg::ENTRY_W-1:0]      ram_rdata;
    logic [ndkl_pkg::DAY_W-1:0]        rd_key;
    logic [ndkl_pkg::VAL_W-1:0]        rd_val;

    logic [ndkl_pkg::CNT_W-1:0]        lo_step, hp_step;
    logic [ndkl_pkg::CNT_W:0]          mid_sum, init_sum;
    logic [ndkl_pkg::IDX_W-1:0]        mid_step, mid_init;
    logic [ndkl_pkg::IDX_W-1:0]        hi_idx, lo_idx;
    logic [ndkl_pkg::DAY_W-1:0]        dlo;
    logic                              table_full;

    logic                              in_search;
    logic [ndkl_pkg::CNT_W-1:0]        mid_wide;
    logic                              load_done;
    logic                              cache_at_reset;

    // absolute distance between two days
    function automatic logic [ndkl_pkg::DAY_W-1:0] abs_diff(
        input logic [ndkl_pkg::DAY_W-1:0] a,
        input logic [ndkl_pkg::DAY_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    // day divider
    ndkl_day_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .timestamp (timestamp),
        .res       (div_res)
    );

    assign day = div_res.day;

    // table memory, key in the upper bits
    ndkl_ram #(
        .DEPTH (ndkl_pkg::TABLE_DEPTH),
        .WIDTH (ndkl_pkg::ENTRY_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ndkl_pkg::IDX_W-1:0]),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_wdata  = {day, val_reg};
    assign rd_key     = ram_rdata[ndkl_pkg::ENTRY_W-1:ndkl_pkg::VAL_W];
    assign rd_val     = ram_rdata[ndkl_pkg::VAL_W-1:0];
    assign table_full = (count_reg >= ndkl_pkg::CNT_W'(ndkl_pkg::TABLE_DEPTH));

    // one binary search step; hp is the upper bound plus one
    always_comb
    begin
        if (rd_key < day)
        begin
            lo_step = ndkl_pkg::CNT_W'(mid_reg) + 1'b1;
            hp_step = hp_reg;
        end
        else
        begin
            lo_step = lo_reg;
            hp_step = ndkl_pkg::CNT_W'(mid_reg);
        end
        mid_sum  = {1'b0, lo_step} + {1'b0, hp_step} - 1'b1;
        mid_step = mid_sum[ndkl_pkg::IDX_W:1];
        init_sum = {1'b0, count_reg} - 1'b1;
        mid_init = init_sum[ndkl_pkg::IDX_W:1];
        // neighbours of the insertion point, clamped to the table ends
        hi_idx   = (hp_step == '0) ? '0 : ndkl_pkg::IDX_W'(hp_step - 1'b1);
        lo_idx   = (lo_step >= count_reg) ? ndkl_pkg::IDX_W'(count_reg - 1'b1)
                                          : ndkl_pkg::IDX_W'(lo_step);
        dlo      = abs_diff(rd_key, day);
    end

    // control state machine
    always_comb
    begin
        state_next        = state_reg;
        op_next           = op_reg;
        val_next          = val_reg;
        count_next        = count_reg;
        cached_day_next   = cached_day_reg;
        cached_value_next = cached_value_reg;
        lo_next           = lo_reg;
        hp_next           = hp_reg;
        mid_next          = mid_reg;
        lo_idx_next       = lo_idx_reg;
        dhi_next          = dhi_reg;
        hval_next         = hval_reg;
        res_next          = res_reg;
        out_value_next    = out_value_reg;
        out_valid_next    = out_valid_reg && out_stall;
        div_start         = 1'b0;
        ram_we            = 1'b0;
        ram_raddr         = mid_reg;
        in_stall          = (state_reg != ndkl_pkg::ST_IDLE);

        unique case (state_reg)
            ndkl_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    div_start  = 1'b1;
                    op_next    = operation;
                    val_next   = entry_value;
                    state_next = ndkl_pkg::ST_DIV;
                end
            end
            ndkl_pkg::ST_DIV:
            begin
                if (div_res.done)
                begin
                    if (op_reg == ndkl_pkg::OP_LOAD)
                    begin
                        // append unless full; any load drops the cache
                        if (!table_full)
                        begin
                            ram_we     = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                        cached_day_next   = '0;
                        cached_value_next = ndkl_pkg::DEFAULT_VALUE;
                        state_next        = ndkl_pkg::ST_IDLE;
                    end
                    else if (count_reg == '0)
                    begin
                        res_next   = ndkl_pkg::DEFAULT_VALUE;
                        state_next = ndkl_pkg::ST_EMIT;
                    end
                    else if (day == cached_day_reg)
                    begin
                        res_next   = cached_value_reg;
                        state_next = ndkl_pkg::ST_EMIT;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hp_next    = count_reg;
                        mid_next   = mid_init;
                        ram_raddr  = mid_init;
                        state_next = ndkl_pkg::ST_SEARCH;
                    end
                end
            end
            ndkl_pkg::ST_SEARCH:
            begin
                if (rd_key == day)
                begin
                    cached_day_next   = day;
                    cached_value_next = rd_val;
                    res_next          = rd_val;
                    state_next        = ndkl_pkg::ST_EMIT;
                end
                else
                begin
                    lo_next = lo_step;
                    hp_next = hp_step;
                    if (lo_step < hp_step)
                    begin
                        mid_next  = mid_step;
                        ram_raddr = mid_step;
                    end
                    else
                    begin
                        ram_raddr   = hi_idx;
                        lo_idx_next = lo_idx;
                        state_next  = ndkl_pkg::ST_NEAR_HI;
                    end
                end
            end
            ndkl_pkg::ST_NEAR_HI:
            begin
                dhi_next   = abs_diff(day, rd_key);
                hval_next  = rd_val;
                ram_raddr  = lo_idx_reg;
                state_next = ndkl_pkg::ST_NEAR_LO;
            end
            ndkl_pkg::ST_NEAR_LO:
            begin
                // lower neighbour only when strictly closer
                cached_day_next = day;
                if (dhi_reg < dlo)
                begin
                    cached_value_next = hval_reg;
                    res_next          = hval_reg;
                end
                else
                begin
                    cached_value_next = rd_val;
                    res_next          = rd_val;
                end
                state_next = ndkl_pkg::ST_EMIT;
            end
            ndkl_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = res_reg;
                    state_next     = ndkl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ndkl_pkg::ST_IDLE;
            end
        endcase
    end

    // state register and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ndkl_pkg::ST_IDLE;
            count_reg        <= '0;
            cached_day_reg   <= '0;
            cached_value_reg <= ndkl_pkg::DEFAULT_VALUE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            cached_day_reg   <= cached_day_next;
            cached_value_reg <= cached_value_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // working registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        lo_reg        <= lo_next;
        hp_reg        <= hp_next;
        mid_reg       <= mid_next;
        lo_idx_reg    <= lo_idx_next;
        dhi_reg       <= dhi_next;
        hval_reg      <= hval_next;
        res_reg       <= res_next;
        out_value_reg <= out_value_next;
    end

    assign out_valid       = out_valid_reg;
    assign looked_up_value = out_value_reg;

    // terms used by the checks
    assign in_search      = (state_reg == ndkl_pkg::ST_SEARCH);
    assign mid_wide       = ndkl_pkg::CNT_W'(mid_reg);
    assign load_done      = (state_reg == ndkl_pkg::ST_DIV) && div_res.done
                            && (op_reg == ndkl_pkg::OP_LOAD);
    assign cache_at_reset = (cached_day_reg == '0)
                            && (cached_value_reg == ndkl_pkg::DEFAULT_VALUE);

    // checks
    `NDKL_ASSERT(a_count_range, count_reg <= ndkl_pkg::CNT_W'(ndkl_pkg::TABLE_DEPTH))
    `NDKL_ASSERT(a_write_room, ram_we |-> !table_full)
    `NDKL_ASSERT(a_search_window, in_search |-> (lo_reg < hp_reg))
    `NDKL_ASSERT(a_mid_window, in_search |-> (mid_wide >= lo_reg && mid_wide < hp_reg))
    `NDKL_ASSERT_NEXT(a_load_clears_cache, load_done, cache_at_reset && !in_stall)

endmodule

`default_nettype wire

/* verif/tb_top.sv */
// testbench for the nearest day key lookup: queued driver, result checker, day table predictor
`timescale 1ns / 1ps

module tb_top;

    localparam int               TS_W            = ndkl_pkg::TS_W;
    localparam int               DAY_W           = ndkl_pkg::DAY_W;
    localparam int               VAL_W           = ndkl_pkg::VAL_W;
    localparam int               TABLE_DEPTH     = ndkl_pkg::TABLE_DEPTH;
    localparam int               SECONDS_PER_DAY = ndkl_pkg::SECONDS_PER_DAY;
    localparam logic             OP_LOAD         = ndkl_pkg::OP_LOAD;
    localparam logic             OP_LOOKUP       = ndkl_pkg::OP_LOOKUP;
    localparam logic [VAL_W-1:0] DEFAULT_VALUE   = ndkl_pkg::DEFAULT_VALUE;

    localparam longint unsigned TS_MAX  = 64'h0000_00FF_FFFF_FFFF;
    localparam longint unsigned DAY_MAX = TS_MAX / SECONDS_PER_DAY;
    // settle wait after draining, well past the time a lookup on a full table takes
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;
    localparam int HOLD_AFTER    = 150;

    typedef struct packed {
        logic             op;
        logic [TS_W-1:0]  ts;
        logic [VAL_W-1:0] val;
    } lookup_req_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic             operation = OP_LOAD;
    logic [TS_W-1:0]  timestamp = '0;
    logic [VAL_W-1:0] entry_value = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [VAL_W-1:0] looked_up_value;

    // stimulus side
    lookup_req_t      pending_items[$];
    lookup_req_t      drv_req;
    logic [DAY_W-1:0] gen_keys[TABLE_DEPTH];
    int               gen_count = 0;
    longint           last_day = 0;
    logic [TS_W-1:0]  last_lookup_ts = '0;
    logic             tail_mode = 1'b0;
    int               send_gap = 0;
    logic             in_taken = 1'b0;

    // receiver side
    int               stall_left = 0;
    int               hold_left = 0;
    logic             long_hold_done = 1'b0;

    // predictor copy of the block state
    logic [DAY_W-1:0] tbl_day[TABLE_DEPTH];
    logic [VAL_W-1:0] tbl_val[TABLE_DEPTH];
    int               tbl_count = 0;
    logic [DAY_W-1:0] cache_day = '0;
    logic [VAL_W-1:0] cache_val = DEFAULT_VALUE;
    logic [VAL_W-1:0] expected_values[$];

    int               mismatches = 0;
    int               results_seen = 0;
    longint unsigned  cycle_count = 0;

    // idling runs in stretches, off entirely in the tail
    wire idle_enabled = !tail_mode && ((cycle_count % 1024) < 768);

    nearest_day_key_lookup u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .timestamp       (timestamp),
        .entry_value     (entry_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .looked_up_value (looked_up_value)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // nearest stored day for a lookup, with the one-entry cache
    function automatic logic [VAL_W-1:0] nearest_value(logic [DAY_W-1:0] day);
        int     lo_idx;
        int     hi_idx;
        int     mid;
        int     pick;
        longint dist_below;
        longint dist_above;
        if (tbl_count == 0)
            return DEFAULT_VALUE;
        if (day == cache_day)
            return cache_val;
        lo_idx = 0;
        hi_idx = tbl_count - 1;
        while (lo_idx <= hi_idx)
        begin
            mid = (lo_idx + hi_idx) / 2;
            if (tbl_day[mid] == day)
            begin
                cache_day = day;
                cache_val = tbl_val[mid];
                return cache_val;
            end
            if (tbl_day[mid] < day)
                lo_idx = mid + 1;
            else
                hi_idx = mid - 1;
        end
        // hi_idx is now the lower neighbour, lo_idx the upper one
        if (hi_idx < 0)
            hi_idx = 0;
        if (lo_idx >= tbl_count)
            lo_idx = tbl_count - 1;
        dist_below = longint'(day) - longint'(tbl_day[hi_idx]);
        dist_above = longint'(tbl_day[lo_idx]) - longint'(day);
        if (dist_below < 0)
            dist_below = -dist_below;
        if (dist_above < 0)
            dist_above = -dist_above;
        // a tie goes to the upper neighbour
        pick = (dist_below < dist_above) ? hi_idx : lo_idx;
        cache_day = day;
        cache_val = tbl_val[pick];
        return cache_val;
    endfunction

    // update the predicted state for one accepted item
    function automatic void apply_item(logic op, logic [TS_W-1:0] ts, logic [VAL_W-1:0] val);
        logic [DAY_W-1:0] day;
        day = DAY_W'(ts / TS_W'(SECONDS_PER_DAY));
        if (op == OP_LOAD)
        begin
            if (tbl_count < TABLE_DEPTH)
            begin
                tbl_day[tbl_count] = day;
                tbl_val[tbl_count] = val;
                tbl_count++;
            end
            cache_day = '0;
            cache_val = DEFAULT_VALUE;
        end
        else
        begin
            expected_values.push_back(nearest_value(day));
        end
    endfunction

    // random second within a day, kept inside the timestamp range
    function automatic logic [TS_W-1:0] ts_in_day(longint day);
        longint unsigned base;
        longint unsigned off;
        base = longint'(day) * SECONDS_PER_DAY;
        off  = $urandom_range(0, SECONDS_PER_DAY - 1);
        if (base + off > TS_MAX)
            off = TS_MAX - base;
        return TS_W'(base + off);
    endfunction

    function automatic logic [TS_W-1:0] rand_ts();
        return TS_W'({$urandom, $urandom});
    endfunction

    function automatic void push_load(logic [TS_W-1:0] ts, logic [VAL_W-1:0] val);
        pending_items.push_back('{OP_LOAD, ts, val});
        if (gen_count < TABLE_DEPTH)
        begin
            gen_keys[gen_count] = DAY_W'(ts / TS_W'(SECONDS_PER_DAY));
            gen_count++;
        end
    endfunction

    function automatic void push_lookup(logic [TS_W-1:0] ts);
        pending_items.push_back('{OP_LOOKUP, ts, VAL_W'($urandom)});
        last_lookup_ts = ts;
    endfunction

    // next load in ascending day order
    function automatic void push_ascending(int max_step);
        last_day = last_day + longint'($urandom_range(0, max_step));
        if (last_day > longint'(DAY_MAX))
            last_day = longint'(DAY_MAX);
        push_load(ts_in_day(last_day), VAL_W'($urandom));
    endfunction

    // one lookup aimed at exact days, midpoints, the cache, random times, the range ends or past the last day
    function automatic void push_aimed_lookup();
        int     sel;
        int     idx;
        longint mid_day;
        sel = $urandom_range(0, 99);
        if (sel < 30)
        begin
            idx = $urandom_range(0, gen_count - 1);
            push_lookup(ts_in_day(gen_keys[idx]));
        end
        else if (sel < 55 && gen_count > 1)
        begin
            idx = $urandom_range(0, gen_count - 2);
            mid_day = (longint'(gen_keys[idx]) + longint'(gen_keys[idx + 1])) / 2
                      + longint'($urandom_range(0, 2)) - 1;
            if (mid_day < 0)
                mid_day = 0;
            push_lookup(ts_in_day(mid_day));
        end
        else if (sel < 70)
        begin
            push_lookup(ts_in_day(last_lookup_ts / TS_W'(SECONDS_PER_DAY)));
        end
        else if (sel < 85)
        begin
            push_lookup(rand_ts());
        end
        else if (sel < 90)
        begin
            push_lookup(ts_in_day(0));
        end
        else if (sel < 95)
        begin
            push_lookup(TS_W'(TS_MAX));
        end
        else
        begin
            push_lookup(ts_in_day(last_day + longint'($urandom_range(0, 50))));
        end
    endfunction

    // sender holds off until every expected result is in
    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_values.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // input driver, changes at the falling edge
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_taken))
        begin
            if (send_gap > 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() != 0)
            begin
                drv_req = pending_items.pop_front();
                operation   <= drv_req.op;
                timestamp   <= drv_req.ts;
                entry_value <= drv_req.val;
                in_valid    <= 1'b1;
                if (idle_enabled && $urandom_range(0, 7) == 0)
                    send_gap <= $urandom_range(1, 14);
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver stall, with one long hold-off once enough results have come
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && results_seen >= HOLD_AFTER)
        begin
            out_stall      <= 1'b1;
            hold_left      <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (idle_enabled && $urandom_range(0, 9) == 0)
        begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 13);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // monitor: predict on input acceptance, check on output acceptance
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        in_taken    <= in_valid && !in_stall;
        if (rst_n && in_valid && !in_stall)
            apply_item(operation, timestamp, entry_value);
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen <= results_seen + 1;
            if (expected_values.size() == 0)
            begin
                $error("looked_up_value %0d arrived with none expected", looked_up_value);
                mismatches++;
            end
            else if (looked_up_value !== expected_values[0])
            begin
                $error("looked_up_value mismatch: expected %0d, actual %0d",
                       expected_values[0], looked_up_value);
                mismatches++;
                void'(expected_values.pop_front());
            end
            else
            begin
                void'(expected_values.pop_front());
            end
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("FAIL nearest_day_key_lookup");
        $finish;
    end

    // stimulus sequence
    initial
    begin
        int n;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table, cache after load, exact, tie, nearest, ends, unordered
        push_lookup('0);
        push_lookup(TS_W'(TS_MAX));
        push_load('0, 8'hA5);
        push_lookup(TS_W'(SECONDS_PER_DAY - 1));
        push_load(ts_in_day(10), 8'hFF);
        push_load(TS_W'(21 * SECONDS_PER_DAY - 1), 8'h00);
        push_load(ts_in_day(31), 8'h3C);
        push_lookup(ts_in_day(10));
        push_lookup(ts_in_day(10));
        push_lookup(ts_in_day(15));
        push_lookup(ts_in_day(14));
        push_lookup(ts_in_day(26));
        push_lookup(TS_W'(TS_MAX));
        push_lookup(ts_in_day(0));
        push_load(ts_in_day(5), 8'h77);
        push_lookup(ts_in_day(5));
        push_lookup(ts_in_day(3));
        push_lookup(ts_in_day(25));
        push_lookup(ts_in_day(40));
        push_lookup('0);
        last_day = 31;
        wait_drained();

        // random mix, mostly ordered loads and aimed lookups
        for (n = 0; n < 340; n++)
        begin
            case ($urandom_range(0, 19))
                0, 1, 2, 3, 4, 5: push_ascending(6);
                6:                push_load(rand_ts(), VAL_W'($urandom));
                default:          push_aimed_lookup();
            endcase
        end
        wait_drained();

        // tail without idling
        tail_mode = 1'b1;
        for (n = 0; n < 40; n++)
            push_aimed_lookup();
        wait_drained();

        if (mismatches == 0 && expected_values.size() == 0)
            $display("PASS nearest_day_key_lookup");
        else
            $display("FAIL nearest_day_key_lookup");
        $finish;
    end

endmodule
